[rtl/core/phd_pkg.sv]
// Shared types, constants and helpers for the pulse height detector.
package phd_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int RAW_W       = 16;
   localparam int AGE_W       = 6;
   localparam int COUNT_W     = 16;
   localparam int MV_W        = 15;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam int MV_SCALE = 10000;
   localparam int MV_SCALE_W = 14;

   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(10);
   localparam logic [AGE_W-1:0]       MAX_AGE_RESET   = AGE_W'(10);
   localparam logic [COUNT_W-1:0]     LIMIT_RESET     = COUNT_W'(1000);

   localparam logic CMD_SAMPLE   = 1'b0;
   localparam logic CMD_TICK     = 1'b1;
   localparam logic KIND_PULSE   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MAX_AGE   = 2'd1,
      CSR_LIMIT     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] threshold;
      logic [AGE_W-1:0]       max_age;
      logic [COUNT_W-1:0]     limit;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] x;
      logic [SAMPLE_BITS-1:0] look;
      logic [SAMPLE_BITS-1:0] prev1;
      logic [SAMPLE_BITS-1:0] prev2;
      logic [SAMPLE_BITS-1:0] prev3;
      logic                   examine;
      logic                   full;
   } tap_type;

   typedef struct packed {
      logic                   kind;
      logic [SAMPLE_BITS-1:0] peak;
      logic [COUNT_W-1:0]     total;
      logic [SAMPLE_BITS-1:0] baseline;
   } cand_type;

   function automatic logic within_one(input logic [SAMPLE_BITS-1:0] a,
                                       input logic [SAMPLE_BITS-1:0] b);
      logic [SAMPLE_BITS:0] ae;
      logic [SAMPLE_BITS:0] be;
      ae = {1'b0, a};
      be = {1'b0, b};
      return (ae == be) || (ae == be + 1'b1) || (be == ae + 1'b1);
   endfunction

endpackage

[rtl/core/phd_window.sv]
// Sample window: clamped shift line with fill count and lookahead taps.
module phd_window #(
   parameter int LOOKAHEAD = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic [phd_pkg::RAW_W-1:0]     sample,
   output phd_pkg::tap_type              taps
);

   localparam int DEPTH  = LOOKAHEAD + 3;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [phd_pkg::SAMPLE_BITS-1:0] win_ff [DEPTH];
   logic [FILL_W-1:0]               fill_ff;
   logic [FILL_W-1:0]               fill_in;
   logic [phd_pkg::SAMPLE_BITS-1:0] clamped;

   // out of range samples map to midscale
   assign clamped = (sample > phd_pkg::RAW_W'(phd_pkg::SAMPLE_MAX))
                    ? phd_pkg::SAMPLE_MID : sample[phd_pkg::SAMPLE_BITS-1:0];

   always_comb begin
      taps.x       = win_ff[LOOKAHEAD-1];
      taps.look    = clamped;
      taps.prev1   = win_ff[LOOKAHEAD];
      taps.prev2   = win_ff[LOOKAHEAD+1];
      taps.prev3   = win_ff[LOOKAHEAD+2];
      taps.examine = fill_ff >= FILL_W'(LOOKAHEAD);
      taps.full    = fill_ff >= FILL_W'(DEPTH);
   end

   always_comb begin
      fill_in = fill_ff;
      if (shift && (fill_ff < FILL_W'(DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         win_ff[0] <= clamped;
         for (int k = 1; k < DEPTH; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

endmodule

[rtl/core/phd_track.sv]
// Baseline tracking, pulse detection and per-second counting.
module phd_track (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  logic                      item_command,
   input  phd_pkg::tap_type          taps,
   input  phd_pkg::cfg_type          cfg,
   input  logic                      take,
   output logic                      fire,
   output logic                      res_valid,
   output phd_pkg::cand_type         res
);

   localparam int SB = phd_pkg::SAMPLE_BITS;

   logic [SB-1:0]                   base_ff, base_in, base_n;
   logic                            in_pulse_ff, in_pulse_in;
   logic [phd_pkg::AGE_W-1:0]       age_ff, age_in, age_n;
   logic [SB-1:0]                   peak_ff, peak_in;
   logic [phd_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            res_valid_ff, res_valid_in;
   phd_pkg::cand_type               res_ff, res_in;
   logic                            produce;
   logic [SB:0]                     level;
   logic                            x_high;
   logic [SB-1:0]                   diff;

   assign fire      = item_valid && (!res_valid_ff || take);
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

   always_comb begin
      base_n = base_ff;
      if (!in_pulse_ff) begin
         if (phd_pkg::within_one(taps.x, base_ff) || phd_pkg::within_one(taps.look, base_ff)) begin
            base_n = base_ff;
         end else if (taps.full && phd_pkg::within_one(taps.prev1, taps.x)
                      && phd_pkg::within_one(taps.prev2, taps.x)
                      && phd_pkg::within_one(taps.prev3, taps.x)) begin
            base_n = taps.x;
         end
      end
   end

   assign level  = {1'b0, base_n} + {1'b0, cfg.threshold};
   assign x_high = {1'b0, taps.x} >= level;
   assign diff   = taps.x - base_n;
   assign age_n  = age_ff + 1'b1;

   always_comb begin
      base_in     = base_ff;
      in_pulse_in = in_pulse_ff;
      age_in      = age_ff;
      peak_in     = peak_ff;
      count_in    = count_ff;
      produce     = 1'b0;
      res_in      = res_ff;
      if (fire) begin
         if (item_command == phd_pkg::CMD_TICK) begin
            produce         = 1'b1;
            res_in.kind     = phd_pkg::KIND_SUMMARY;
            res_in.peak     = '0;
            res_in.total    = count_ff;
            res_in.baseline = base_ff;
            count_in        = '0;
         end else if (taps.examine) begin
            base_in = base_n;
            if (base_n != '0) begin
               if (!in_pulse_ff) begin
                  if (x_high) begin
                     in_pulse_in = 1'b1;
                     age_in      = '0;
                     peak_in     = diff;
                  end
               end else if (!x_high) begin
                  in_pulse_in = 1'b0;
                  age_in      = '0;
                  if (count_ff < cfg.limit) begin
                     count_in        = count_ff + 1'b1;
                     produce         = 1'b1;
                     res_in.kind     = phd_pkg::KIND_PULSE;
                     res_in.peak     = peak_ff;
                     res_in.total    = count_ff + 1'b1;
                     res_in.baseline = base_n;
                  end
               end else if (age_n >= cfg.max_age) begin
                  // pulse ran too long: drop it
                  in_pulse_in = 1'b0;
                  age_in      = '0;
                  peak_in     = '0;
               end else begin
                  age_in = age_n;
                  if (diff > peak_ff) begin
                     peak_in = diff;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      res_valid_in = res_valid_ff;
      if (fire) begin
         res_valid_in = produce;
      end else if (take) begin
         res_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         in_pulse_ff  <= 1'b0;
         age_ff       <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         in_pulse_ff  <= in_pulse_in;
         age_ff       <= age_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

[rtl/core/phd_scale.sv]
// Millivolt scaling and result output register.
module phd_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              res_valid,
   input  phd_pkg::cand_type                 res,
   input  logic                              rsp_stall,
   output logic                              take,
   output logic                              rsp_valid,
   output logic                              rsp_kind,
   output logic [phd_pkg::MV_W-1:0]          rsp_peak_mv,
   output logic [phd_pkg::COUNT_W-1:0]       rsp_pulse_total,
   output logic [phd_pkg::SAMPLE_BITS-1:0]   rsp_baseline_level
);

   localparam int PROD_W = phd_pkg::SAMPLE_BITS + phd_pkg::MV_SCALE_W;

   logic [PROD_W-1:0]                product;
   logic                             valid_ff, valid_in;
   logic                             kind_ff;
   logic [phd_pkg::MV_W-1:0]         mv_ff, mv_in;
   logic [phd_pkg::COUNT_W-1:0]      total_ff;
   logic [phd_pkg::SAMPLE_BITS-1:0]  base_ff;

   assign take = !valid_ff || !rsp_stall;

   // height = peak * 10000 / midscale, truncated
   assign product  = PROD_W'(res.peak) * PROD_W'(phd_pkg::MV_SCALE);
   assign mv_in    = phd_pkg::MV_W'(product >> (phd_pkg::SAMPLE_BITS - 1));
   assign valid_in = take ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         kind_ff  <= res.kind;
         mv_ff    <= mv_in;
         total_ff <= res.total;
         base_ff  <= res.baseline;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_peak_mv        = mv_ff;
   assign rsp_pulse_total    = total_ff;
   assign rsp_baseline_level = base_ff;

endmodule

[rtl/core/pulse_height_detector_core.sv]
// Top level of the pulse height detector: input stage, control registers, core units.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    req_command, req_sample
//   rsp      out        rsp_valid / rsp_stall    rsp_kind, rsp_peak_mv, rsp_pulse_total,
//                                                rsp_baseline_level
//   csr      in         csr_write_enable         csr_index, csr_write_data
//
// One transfer per cycle on each side when nothing stalls. An item passes from req to
// rsp through the input register, the tracking stage (window, baseline, pulse state,
// counter) and the scaling multiply before the output register. The tracking state
// closes its loop per item, which sets the rate of one item per clock when unstalled.
// Reset is synchronous and clears all control state; the register file returns to
// threshold 10, pulse age 10, limit 1000. Each stage loads whenever it is empty or
// its content moves on, so a stalled rsp holds the result while empty stages still
// take transfers; req_stall rises only once every stage holds work.
module pulse_height_detector_core #(
   parameter int LOOKAHEAD = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [phd_pkg::RAW_W-1:0]           req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [phd_pkg::MV_W-1:0]            rsp_peak_mv,
   output logic [phd_pkg::COUNT_W-1:0]         rsp_pulse_total,
   output logic [phd_pkg::SAMPLE_BITS-1:0]     rsp_baseline_level,
   input  logic                                csr_write_enable,
   input  logic [phd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [phd_pkg::CSR_W-1:0]           csr_write_data
);

   // control registers
   phd_pkg::cfg_type cfg_ff, cfg_in;

   // input stage
   logic                        item_valid_ff, item_valid_in;
   logic                        item_command_ff;
   logic [phd_pkg::RAW_W-1:0]   item_sample_ff;
   logic                        req_take;

   // links between units
   logic                        fire;
   logic                        take;
   logic                        res_valid;
   phd_pkg::cand_type           res;
   phd_pkg::tap_type            taps;

   // advance the input stage when it is empty or its item enters tracking
   assign req_take  = !item_valid_ff || fire;
   assign req_stall = !req_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (phd_pkg::csr_index_type'(csr_index))
            phd_pkg::CSR_THRESHOLD: begin
               cfg_in.threshold = csr_write_data[phd_pkg::SAMPLE_BITS-1:0];
            end
            phd_pkg::CSR_MAX_AGE: begin
               cfg_in.max_age = csr_write_data[phd_pkg::AGE_W-1:0];
            end
            phd_pkg::CSR_LIMIT: begin
               cfg_in.limit = csr_write_data[phd_pkg::COUNT_W-1:0];
            end
            default: begin
               // drop writes to unknown indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign item_valid_in = req_take ? req_valid : item_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= phd_pkg::THRESHOLD_RESET;
         cfg_ff.max_age   <= phd_pkg::MAX_AGE_RESET;
         cfg_ff.limit     <= phd_pkg::LIMIT_RESET;
         item_valid_ff    <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
      end
   end

   // hold the payload while the stage is busy
   always_ff @(posedge clock) begin
      if (req_take && req_valid) begin
         item_command_ff <= req_command;
         item_sample_ff  <= req_sample;
      end
   end

   // window advances on sample items only; ticks leave it untouched
   phd_window #(
      .LOOKAHEAD (LOOKAHEAD)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .shift  (fire && (item_command_ff == phd_pkg::CMD_SAMPLE)),
      .sample (item_sample_ff),
      .taps   (taps)
   );

   phd_track u_track (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (item_valid_ff),
      .item_command (item_command_ff),
      .taps         (taps),
      .cfg          (cfg_ff),
      .take         (take),
      .fire         (fire),
      .res_valid    (res_valid),
      .res          (res)
   );

   phd_scale u_scale (
      .clock              (clock),
      .reset              (reset),
      .res_valid          (res_valid),
      .res                (res),
      .rsp_stall          (rsp_stall),
      .take               (take),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_peak_mv        (rsp_peak_mv),
      .rsp_pulse_total    (rsp_pulse_total),
      .rsp_baseline_level (rsp_baseline_level)
   );

endmodule

[dv/pulse_height_detector_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for pulse_height_detector_core: directed and random sample streams.
module pulse_height_detector_core_test;
   import phd_pkg::*;

   localparam int CLK_HALF      = 1;
   localparam int RESET_CYCLES  = 10;
   localparam int LOOKAHEAD     = 10;
   localparam int WIN_DEPTH     = LOOKAHEAD + 4;
   // three stages from req to rsp; leave margin for items that make no report
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_SHOWN     = 10;
   localparam int TIMEOUT_NS    = 2000000;
   // index 3 is not decoded by the register file
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // one report leaving the detector
   typedef struct {
      logic                   kind;
      logic [MV_W-1:0]        peak_mv;
      logic [COUNT_W-1:0]     total;
      logic [SAMPLE_BITS-1:0] baseline;
   } report_type;

   // DUT ports; every input starts at a known value
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_command = CMD_SAMPLE;
   logic [RAW_W-1:0]       req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_kind;
   logic [MV_W-1:0]        rsp_peak_mv;
   logic [COUNT_W-1:0]     rsp_pulse_total;
   logic [SAMPLE_BITS-1:0] rsp_baseline_level;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_W-1:0]       csr_write_data = '0;

   // predicted detector state and register copy
   logic [SAMPLE_BITS-1:0] sample_hist [WIN_DEPTH];
   int                     hist_fill;
   logic [SAMPLE_BITS-1:0] base_lvl;
   logic                   pulse_open;
   logic [AGE_W-1:0]       pulse_len;
   logic [SAMPLE_BITS-1:0] pulse_peak;
   logic [COUNT_W-1:0]     sec_pulses;
   logic [SAMPLE_BITS-1:0] cfg_threshold;
   logic [AGE_W-1:0]       cfg_max_age;
   logic [COUNT_W-1:0]     cfg_limit;

   report_type expected_reports[$];

   // traffic shaping
   int gap_pct = 0;
   int gap_max = 1;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_max = 1;
   int stall_run = 0;
   logic stall_now = 1'b0;
   int tick_permille = 20;
   int train_level = 100;

   // bookkeeping
   int fault_count = 0;
   int n_sent = 0;
   int n_samples = 0;
   int n_ticks = 0;
   int n_csr = 0;
   int n_phases = 0;
   int n_pulse_seen = 0;
   int n_summary_seen = 0;

   pulse_height_detector_core #(
      .LOOKAHEAD(LOOKAHEAD)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_peak_mv        (rsp_peak_mv),
      .rsp_pulse_total    (rsp_pulse_total),
      .rsp_baseline_level (rsp_baseline_level),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // ------------------------------------------------------------------
   // Detector prediction
   // ------------------------------------------------------------------

   function automatic logic near_level(input int a, input int b);
      return (a >= b - 1) && (a <= b + 1);
   endfunction

   function automatic void clear_tracker();
      for (int i = 0; i < WIN_DEPTH; i++) sample_hist[i] = '0;
      hist_fill     = 0;
      base_lvl      = '0;
      pulse_open    = 1'b0;
      pulse_len     = '0;
      pulse_peak    = '0;
      sec_pulses    = '0;
      cfg_threshold = THRESHOLD_RESET;
      cfg_max_age   = MAX_AGE_RESET;
      cfg_limit     = LIMIT_RESET;
   endfunction

   // Advance the predicted state by one accepted transfer; queue any report it causes.
   function automatic void track_item(input logic cmd, input logic [RAW_W-1:0] raw);
      report_type rpt;
      int         x;
      int         b;
      int         start_lvl;
      if (cmd == CMD_TICK) begin
         rpt.kind      = KIND_SUMMARY;
         rpt.peak_mv   = '0;
         rpt.total     = sec_pulses;
         rpt.baseline  = base_lvl;
         expected_reports.push_back(rpt);
         sec_pulses = '0;
         n_ticks++;
         return;
      end
      n_samples++;
      for (int i = WIN_DEPTH - 1; i > 0; i--) sample_hist[i] = sample_hist[i-1];
      sample_hist[0] = (raw > RAW_W'(SAMPLE_MAX)) ? SAMPLE_MID : raw[SAMPLE_BITS-1:0];
      if (hist_fill < WIN_DEPTH) hist_fill++;
      if (hist_fill < LOOKAHEAD + 1) return;

      x = int'(sample_hist[LOOKAHEAD]);
      b = int'(base_lvl);
      // outside a pulse, move the baseline to a settled examined sample
      if (!pulse_open && !near_level(x, b) && !near_level(int'(sample_hist[0]), b) &&
          hist_fill >= WIN_DEPTH &&
          near_level(int'(sample_hist[LOOKAHEAD+1]), x) &&
          near_level(int'(sample_hist[LOOKAHEAD+2]), x) &&
          near_level(int'(sample_hist[LOOKAHEAD+3]), x)) begin
         base_lvl = sample_hist[LOOKAHEAD];
         b = x;
      end
      if (b == 0) return;

      start_lvl = b + int'(cfg_threshold);
      if (!pulse_open) begin
         if (x >= start_lvl) begin
            pulse_open = 1'b1;
            pulse_len  = '0;
            pulse_peak = SAMPLE_BITS'(x - b);
         end
         return;
      end
      if (x < start_lvl) begin
         pulse_open = 1'b0;
         pulse_len  = '0;
         if (sec_pulses < cfg_limit) begin
            sec_pulses++;
            rpt.kind      = KIND_PULSE;
            rpt.peak_mv   = MV_W'((int'(pulse_peak) * MV_SCALE) / int'(SAMPLE_MID));
            rpt.total     = sec_pulses;
            rpt.baseline  = base_lvl;
            expected_reports.push_back(rpt);
         end
         return;
      end
      pulse_len++;
      if (pulse_len >= cfg_max_age) begin
         pulse_open = 1'b0;
         pulse_len  = '0;
         pulse_peak = '0;
         return;
      end
      if (x - b > int'(pulse_peak)) pulse_peak = SAMPLE_BITS'(x - b);
   endfunction

   // ------------------------------------------------------------------
   // Report checking
   // ------------------------------------------------------------------

   function automatic void report_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_SHOWN) $display("[%0t] %s", $time, what);
   endfunction

   // Compare each rsp transfer with the oldest queued report.
   always @(posedge clock) begin
      report_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_kind == KIND_PULSE) n_pulse_seen++;
         else n_summary_seen++;
         if (expected_reports.size() == 0) begin
            report_fault($sformatf("unexpected report: kind %0d mv %0d total %0d base %0d",
                                   rsp_kind, rsp_peak_mv, rsp_pulse_total,
                                   rsp_baseline_level));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_kind !== want.kind || rsp_peak_mv !== want.peak_mv ||
                rsp_pulse_total !== want.total || rsp_baseline_level !== want.baseline) begin
               report_fault($sformatf({"report mismatch: expected kind %0d mv %0d total %0d ",
                                       "base %0d, got kind %0d mv %0d total %0d base %0d"},
                                      want.kind, want.peak_mv, want.total, want.baseline,
                                      rsp_kind, rsp_peak_mv, rsp_pulse_total,
                                      rsp_baseline_level));
            end
         end
      end
   end

   // Stall the rsp side in runs of random length; stall_pct of zero never stalls.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_now = ($urandom_range(0, 99) < stall_pct);
         stall_run = stall_now ? $urandom_range(1, stall_max) : $urandom_range(1, 12);
      end
      stall_run--;
      rsp_stall <= stall_now;
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Present one item on req and hold it until the transfer happens.
   task automatic send_item(input logic cmd, input logic [RAW_W-1:0] raw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, gap_max) : 0;
         if (gap > 0) begin
            // drop valid for the gap and scramble the idle payload
            req_valid   <= 1'b0;
            req_command <= 1'($urandom);
            req_sample  <= RAW_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_sample  <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      track_item(cmd, raw);
   endtask

   // Send a sample, sometimes preceded by a tick carrying a junk sample field.
   task automatic send_sample(input int value);
      if ($urandom_range(0, 999) < tick_permille) send_item(CMD_TICK, RAW_W'($urandom));
      send_item(CMD_SAMPLE, RAW_W'(value));
   endtask

   // Drop valid, wait for every queued report, then let the pipeline settle.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register while the block is idle; mirror it in the predictor.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      n_csr++;
      case (idx)
         CSR_THRESHOLD: cfg_threshold = data[SAMPLE_BITS-1:0];
         CSR_MAX_AGE:   cfg_max_age   = data[AGE_W-1:0];
         CSR_LIMIT:     cfg_limit     = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Load all three registers; junk above the threshold and age widths must be ignored.
   task automatic apply_settings(input int thr, input int age, input int lim);
      logic [CSR_W-1:0] data;
      data = CSR_W'($urandom);
      data[SAMPLE_BITS-1:0] = SAMPLE_BITS'(thr);
      write_csr(CSR_THRESHOLD, data);
      data = CSR_W'($urandom);
      data[AGE_W-1:0] = AGE_W'(age);
      write_csr(CSR_MAX_AGE, data);
      write_csr(CSR_LIMIT, CSR_W'(lim));
      n_phases++;
   endtask

   task automatic set_traffic(input int gp, input int gm, input int sp, input int sm);
      gap_pct   = gp;
      gap_max   = gm;
      stall_pct = sp;
      stall_max = sm;
   endtask

   // ------------------------------------------------------------------
   // Random stream shapes
   // ------------------------------------------------------------------

   function automatic int pick_level();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, 3);
         1:       return $urandom_range(int'(SAMPLE_MAX) - 100, int'(SAMPLE_MAX));
         default: return $urandom_range(4, 3000);
      endcase
   endfunction

   function automatic int noisy(input int lvl);
      int v;
      v = lvl + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      return v;
   endfunction

   // Flat stretch near the level, one pulse of random width and height, short tail.
   task automatic send_pulse_train();
      int flat_len;
      int width;
      int age_cap;
      int lo;
      int hi;
      if ($urandom_range(0, 4) == 0) train_level = pick_level();
      flat_len = $urandom_range(4, 18);
      repeat (flat_len) send_sample(noisy(train_level));
      age_cap = int'(cfg_max_age);
      if (age_cap < 1) age_cap = 1;
      // mostly short enough to survive; now and then too long
      if ($urandom_range(0, 7) == 0) width = $urandom_range(1, age_cap + 4);
      else width = $urandom_range(1, (age_cap > 12) ? 12 : age_cap);
      lo = train_level + int'(cfg_threshold);
      if (lo > int'(SAMPLE_MAX)) lo = int'(SAMPLE_MAX);
      hi = $urandom_range(lo, int'(SAMPLE_MAX));
      repeat (width) begin
         if ($urandom_range(0, 19) == 0)
            send_sample($urandom_range(int'(SAMPLE_MAX) + 1, 65535));
         else
            send_sample($urandom_range(lo, hi));
      end
      repeat ($urandom_range(1, 4)) send_sample(noisy(train_level));
   endtask

   task automatic send_noise_burst();
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 5))
            0:       send_sample(0);
            1:       send_sample(int'(SAMPLE_MAX));
            2:       send_sample(int'(SAMPLE_MAX) + 1);
            3:       send_sample(65535);
            default: send_sample(int'(RAW_W'($urandom)));
         endcase
      end
   endtask

   // Mix of well-formed pulse trains, level steps and noise; drain at the end.
   task automatic run_random_phase(input int n);
      int stop_at;
      stop_at = n_sent + n;
      while (n_sent < stop_at) begin
         case ($urandom_range(0, 19))
            0, 1, 2: send_noise_burst();
            3, 4: begin
               train_level = pick_level();
               repeat ($urandom_range(2, 14)) send_sample(noisy(train_level));
            end
            default: send_pulse_train();
         endcase
      end
      drain_pipeline();
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset registers: window filling, zero baseline, clamped samples, one pulse,
   // ticks before, during and after it.
   task automatic test_reset_values();
      set_traffic(0, 1, 0, 1);
      send_item(CMD_TICK, '1);
      send_item(CMD_SAMPLE, 16'hFFFF);
      send_item(CMD_SAMPLE, RAW_W'(SAMPLE_MAX) + 1'b1);
      send_item(CMD_SAMPLE, RAW_W'(SAMPLE_MAX));
      send_item(CMD_SAMPLE, '0);
      repeat (8) send_item(CMD_SAMPLE, 16'd100);
      send_item(CMD_SAMPLE, 16'd300);
      send_item(CMD_SAMPLE, RAW_W'(SAMPLE_MAX));
      repeat (9) send_item(CMD_SAMPLE, 16'd100);
      send_item(CMD_TICK, '0);
      repeat (2) send_item(CMD_SAMPLE, 16'd100);
      send_item(CMD_TICK, 16'h5A5A);
      drain_pipeline();
   endtask

   // A write to the undecoded index must leave all registers alone.
   task automatic test_ignored_index();
      write_csr(CSR_UNUSED, CSR_W'($urandom));
      write_csr(CSR_UNUSED, '1);
      set_traffic(20, 4, 20, 6);
      run_random_phase(60);
   endtask

   task automatic test_extreme_settings();
      set_traffic(0, 1, 0, 1);
      apply_settings(1, 63, 65535);
      run_random_phase(150);
      set_traffic(40, 8, 50, 30);
      apply_settings(int'(SAMPLE_MAX), 1, 0);
      run_random_phase(120);
   endtask

   // Small per-second limits, including zero, with ticks a little rarer than elsewhere.
   task automatic test_count_limit();
      tick_permille = 15;
      set_traffic(10, 3, 30, 10);
      apply_settings(8, 20, 2);
      run_random_phase(120);
      apply_settings(8, 20, 0);
      run_random_phase(50);
      apply_settings(3, 12, 1);
      run_random_phase(60);
      tick_permille = 20;
   endtask

   // Short age limits drop most wide pulses.
   task automatic test_pulse_age();
      set_traffic(25, 5, 10, 40);
      apply_settings(5, 1, 1000);
      run_random_phase(110);
      apply_settings(5, 3, 1000);
      run_random_phase(110);
   endtask

   task automatic test_random_settings();
      repeat (4) begin
         set_traffic($urandom_range(0, 50), $urandom_range(1, 8),
                     $urandom_range(0, 60), $urandom_range(1, 30));
         apply_settings(($urandom_range(0, 5) == 0) ? $urandom_range(1, int'(SAMPLE_MAX))
                                                    : $urandom_range(1, 200),
                        $urandom_range(1, 63),
                        ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 65535));
         run_random_phase(120);
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      clear_tracker();
      // hold reset, then release it for good
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_ignored_index();
      test_extreme_settings();
      test_count_limit();
      test_pulse_age();
      test_random_settings();

      drain_pipeline();
      $display("Sent %0d samples and %0d ticks over %0d register settings (%0d writes).",
               n_samples, n_ticks, n_phases, n_csr);
      $display("Checked %0d pulse reports and %0d per-second summaries, %0d faults.",
               n_pulse_seen, n_summary_seen, fault_count);
      if (fault_count == 0 && expected_reports.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: stop a hung run.
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

[pulse_height_detector_core.f]
rtl/core/phd_pkg.sv
rtl/core/phd_window.sv
rtl/core/phd_track.sv
rtl/core/phd_scale.sv
rtl/core/pulse_height_detector_core.sv
dv/pulse_height_detector_core_test.sv
